// ===== rtl/core/bes_pkg.sv =====
// Shared types, constants and helpers for the bulb exposure sequencer.
// Used by every module under rtl/core; depends on nothing else.
package bes_pkg;

    // Time base and field widths
    localparam int TIME_BITS = 34;
    localparam int OUT_W     = 34;
    localparam int CMP_W     = ((TIME_BITS > OUT_W) ? TIME_BITS : OUT_W) + 2;
    localparam int FOCUS_W   = 26;
    localparam int CFG_W     = 32;
    localparam int IDX_W     = 3;

    localparam logic [TIME_BITS-1:0] TIME_MAX   = {TIME_BITS{1'b1}};
    localparam logic [FOCUS_W-1:0]   US_PER_MS  = FOCUS_W'(1000);
    localparam logic [CFG_W-1:0]     TIMEOUT_RST = CFG_W'(1000000);

    // Sequencer phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_FOCUS   = 3'd1;
    localparam logic [2:0] PH_SYNCIN  = 3'd2;
    localparam logic [2:0] PH_HOLD    = 3'd3;
    localparam logic [2:0] PH_SYNCOUT = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_ERROR   = 3'd6;

    // Item functions
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_FAIL  = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_SYNC    = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT = 2'd2;
    localparam logic [1:0] ERR_SEQ     = 2'd3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_BULB        = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_LAG   = 3'd1;
    localparam logic [IDX_W-1:0] REG_END_LAG     = 3'd2;
    localparam logic [IDX_W-1:0] REG_PRE_FOCUS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_EXPECT_SYNC = 3'd4;
    localparam logic [IDX_W-1:0] REG_RUN_TEST    = 3'd5;
    localparam logic [IDX_W-1:0] REG_TIMEOUT     = 3'd6;

    typedef struct packed {
        logic func;
        logic sync_level;
    } bes_in_t;

    typedef struct packed {
        logic             shutter;
        logic             focus;
        logic [1:0]       status;
        logic [1:0]       error_code;
        logic [OUT_W-1:0] start_diff;
        logic [OUT_W-1:0] stop_diff;
        logic [OUT_W-1:0] actual_time;
    } bes_out_t;

    // Thresholds derived from the configuration, test mode already applied
    typedef struct packed {
        logic signed [CMP_W-1:0] hold_limit;
        logic signed [CMP_W-1:0] lag_limit;
        logic signed [CMP_W-1:0] timeout_limit;
        logic [15:0]             pre_focus_ms;
        logic                    expect_sync;
    } bes_limits_t;

    // Zero-extend a time value for signed comparison
    function automatic logic signed [CMP_W-1:0] to_cmp(input logic [TIME_BITS-1:0] x);
        return $signed(CMP_W'(x));
    endfunction

    // Fit a time value to the output field width
    function automatic logic [OUT_W-1:0] to_out(input logic [TIME_BITS-1:0] x);
        logic [CMP_W-1:0] t;
        t = CMP_W'(x);
        return t[OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/bes_cfg.sv =====
// Configuration register file and derived run thresholds.
// Depends on bes_pkg.
module bes_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bes_pkg::IDX_W-1:0]  cfg_index,
    input  logic [bes_pkg::CFG_W-1:0]  cfg_data,
    output bes_pkg::bes_limits_t       limits
);
    import bes_pkg::*;

    logic [CFG_W-1:0] bulb_reg;
    logic [CFG_W-1:0] start_lag_reg;
    logic [CFG_W-1:0] end_lag_reg;
    logic [15:0]      pre_focus_reg;
    logic             expect_sync_reg;
    logic             run_test_reg;
    logic [CFG_W-1:0] timeout_reg;

    logic [CFG_W-1:0] bulb_eff;
    logic [CFG_W-1:0] start_eff;
    logic [CFG_W-1:0] end_eff;

    assign cfg_ready = 1'b1;

    // Write registers; unknown indexes drop the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bulb_reg        <= '0;
            start_lag_reg   <= '0;
            end_lag_reg     <= '0;
            pre_focus_reg   <= '0;
            expect_sync_reg <= 1'b1;
            run_test_reg    <= 1'b0;
            timeout_reg     <= TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BULB:        bulb_reg        <= cfg_data;
                REG_START_LAG:   start_lag_reg   <= cfg_data;
                REG_END_LAG:     end_lag_reg     <= cfg_data;
                REG_PRE_FOCUS:   pre_focus_reg   <= cfg_data[15:0];
                REG_EXPECT_SYNC: expect_sync_reg <= cfg_data[0];
                REG_RUN_TEST:    run_test_reg    <= cfg_data[0];
                REG_TIMEOUT:     timeout_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Test mode zeroes the bulb and lag times and forces sync to be expected
    assign bulb_eff  = run_test_reg ? '0 : bulb_reg;
    assign start_eff = run_test_reg ? '0 : start_lag_reg;
    assign end_eff   = run_test_reg ? '0 : end_lag_reg;

    // Derive comparison limits
    always_comb
    begin
        limits.hold_limit    = $signed(CMP_W'(bulb_eff)) - $signed(CMP_W'(end_eff));
        limits.lag_limit     = $signed(CMP_W'(bulb_eff)) + $signed(CMP_W'(start_eff))
                             - $signed(CMP_W'(end_eff));
        limits.timeout_limit = $signed(CMP_W'(timeout_reg)) + $signed(CMP_W'(bulb_eff));
        limits.pre_focus_ms  = pre_focus_reg;
        limits.expect_sync   = run_test_reg | expect_sync_reg;
    end

endmodule

// ===== rtl/core/bes_seq.sv =====
// Sequencer state and next-state logic; one transaction advances it one step.
// Depends on bes_pkg.
module bes_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  bes_pkg::bes_in_t     item,
    input  bes_pkg::bes_limits_t limits,
    output bes_pkg::bes_out_t    result_next
);
    import bes_pkg::*;

    logic [2:0]           phase_reg,     phase_next;
    logic                 last_sync_reg, last_sync_next;
    logic [FOCUS_W-1:0]   focus_wait_reg, focus_wait_next;
    logic [TIME_BITS-1:0] elapsed_reg,   elapsed_next;
    logic [TIME_BITS-1:0] syncin_reg,    syncin_next;
    logic [TIME_BITS-1:0] stop_reg,      stop_next;
    logic [TIME_BITS-1:0] syncout_reg,   syncout_next;
    logic [1:0]           fault_reg,     fault_next;

    logic [TIME_BITS-1:0] elapsed_inc;
    logic [TIME_BITS-1:0] stamp_in;
    logic [TIME_BITS-1:0] hold_diff;
    logic [FOCUS_W-1:0]   focus_dec;
    logic [2:0]           phase_edge;
    logic                 run_active;
    logic                 may_start;

    assign elapsed_inc = (elapsed_reg == TIME_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign focus_dec   = (focus_wait_reg != '0) ? focus_wait_reg - 1'b1 : focus_wait_reg;
    assign run_active  = (phase_reg == PH_SYNCIN) || (phase_reg == PH_HOLD)
                      || (phase_reg == PH_SYNCOUT);
    assign may_start   = (phase_reg == PH_IDLE) || (phase_reg == PH_DONE)
                      || (phase_reg == PH_ERROR);

    // Next state for one transaction
    always_comb
    begin
        phase_next      = phase_reg;
        last_sync_next  = last_sync_reg;
        focus_wait_next = focus_wait_reg;
        elapsed_next    = elapsed_reg;
        syncin_next     = syncin_reg;
        stop_next       = stop_reg;
        syncout_next    = syncout_reg;
        fault_next      = fault_reg;
        phase_edge      = phase_reg;
        stamp_in        = syncin_reg;
        hold_diff       = '0;

        if (item.func == FUNC_START)
        begin
            // Start a new run unless one is in progress
            if (may_start)
            begin
                fault_next      = ERR_NONE;
                elapsed_next    = '0;
                syncin_next     = '0;
                stop_next       = '0;
                syncout_next    = '0;
                focus_wait_next = '0;
                last_sync_next  = 1'b1;
                if (!item.sync_level)
                begin
                    fault_next = ERR_SYNC;
                    phase_next = PH_ERROR;
                end
                else if (limits.pre_focus_ms == '0)
                begin
                    phase_next = PH_SYNCIN;
                end
                else
                begin
                    focus_wait_next = FOCUS_W'(limits.pre_focus_ms) * US_PER_MS;
                    phase_next      = PH_FOCUS;
                end
            end
        end
        else if (phase_reg == PH_FOCUS)
        begin
            // Count down focus time, then raise shutter
            focus_wait_next = focus_dec;
            if (focus_dec == '0)
            begin
                elapsed_next   = '0;
                last_sync_next = 1'b1;
                phase_next     = PH_SYNCIN;
            end
        end
        else if (run_active)
        begin
            elapsed_next = elapsed_inc;

            // Check sync edge
            if (item.sync_level != last_sync_reg)
            begin
                if ((phase_reg == PH_SYNCIN) && !item.sync_level)
                begin
                    syncin_next = elapsed_inc;
                    stamp_in    = elapsed_inc;
                    phase_edge  = PH_HOLD;
                end
                else if ((phase_reg == PH_SYNCOUT) && item.sync_level)
                begin
                    syncout_next = elapsed_inc;
                    phase_edge   = PH_DONE;
                end
                else
                begin
                    fault_next = ERR_SEQ;
                    phase_edge = PH_ERROR;
                end
                last_sync_next = item.sync_level;
            end
            phase_next = phase_edge;

            // Hold release or timeout
            hold_diff = elapsed_inc - stamp_in;
            if (phase_edge == PH_HOLD)
            begin
                if (to_cmp(hold_diff) >= limits.hold_limit)
                begin
                    stop_next  = elapsed_inc;
                    phase_next = PH_SYNCOUT;
                end
            end
            else if ((!limits.expect_sync && (phase_edge == PH_SYNCIN)
                      && (to_cmp(elapsed_inc) > limits.lag_limit))
                     || (to_cmp(elapsed_inc) > limits.timeout_limit))
            begin
                fault_next = ERR_TIMEOUT;
                phase_next = PH_ERROR;
            end
        end
    end

    // Advance state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            last_sync_reg  <= 1'b1;
            focus_wait_reg <= '0;
            elapsed_reg    <= '0;
            syncin_reg     <= '0;
            stop_reg       <= '0;
            syncout_reg    <= '0;
            fault_reg      <= ERR_NONE;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            last_sync_reg  <= last_sync_next;
            focus_wait_reg <= focus_wait_next;
            elapsed_reg    <= elapsed_next;
            syncin_reg     <= syncin_next;
            stop_reg       <= stop_next;
            syncout_reg    <= syncout_next;
            fault_reg      <= fault_next;
        end
    end

    // Build result from the new state
    always_comb
    begin
        result_next.shutter    = (phase_next == PH_SYNCIN) || (phase_next == PH_HOLD);
        result_next.focus      = (phase_next == PH_FOCUS) || (phase_next == PH_SYNCIN)
                              || (phase_next == PH_HOLD);
        result_next.error_code = fault_next;
        case (phase_next)
            PH_IDLE:  result_next.status = ST_IDLE;
            PH_DONE:  result_next.status = ST_DONE;
            PH_ERROR: result_next.status = ST_FAIL;
            default:  result_next.status = ST_BUSY;
        endcase
        if (phase_next == PH_DONE)
        begin
            result_next.start_diff  = to_out(syncin_next);
            result_next.stop_diff   = to_out(syncout_next - stop_next);
            result_next.actual_time = to_out(syncout_next - syncin_next);
        end
        else
        begin
            result_next.start_diff  = '0;
            result_next.stop_diff   = '0;
            result_next.actual_time = '0;
        end
    end

endmodule

// ===== rtl/core/bes_out.sv =====
// Result register with valid/ready handshake toward the consumer.
// Depends on bes_pkg.
module bes_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  bes_pkg::bes_out_t result_next,
    output logic              take_ready,
    output logic              result_valid,
    input  logic              result_ready,
    output bes_pkg::bes_out_t result
);
    import bes_pkg::*;

    logic     valid_reg;
    bes_out_t result_reg;

    // Accept a new transaction when the slot is empty or draining
    assign take_ready   = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    // Track slot occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept || (valid_reg && !result_ready);
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== rtl/core/bulb_exposure_sequencer_top.sv =====
// Bulb exposure sequencer top level: one result per item, held in a result register.
// Throughput: one item per cycle unless the result register stalls intake; each item updates the sequencer state once.
// Latency: the result is valid in the cycle after the item's transaction.
// The result register stalls intake only while a result waits and the consumer is not ready.
// Reset (rst_n low, asynchronous): idle phase, registers at defaults, no result pending.
// Depends on bes_pkg, bes_cfg, bes_seq and bes_out.
module bulb_exposure_sequencer_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  bes_pkg::bes_in_t          item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output bes_pkg::bes_out_t         result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bes_pkg::IDX_W-1:0] cfg_index,
    input  logic [bes_pkg::CFG_W-1:0] cfg_data
);
    import bes_pkg::*;

    bes_limits_t limits;
    bes_out_t    result_next;
    logic        accept;

    assign accept = item_valid && item_ready;

    bes_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    bes_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .limits      (limits),
        .result_next (result_next)
    );

    bes_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .result_next  (result_next),
        .take_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Every transaction yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
    else $error("result missing after transaction");

    // Shutter is never driven without focus
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.shutter || result.focus))
    else $error("shutter without focus");

    // Error code is set exactly when the run ended in error
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.error_code != ERR_NONE) == (result.status == ST_FAIL)))
    else $error("error code and status disagree");

    // Time fields stay zero unless the run is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != ST_DONE)) |->
            ((result.start_diff == '0) && (result.stop_diff == '0)
             && (result.actual_time == '0)))
    else $error("time fields set outside done");

endmodule

// ===== verif/tb_bulb_exposure_sequencer_top.sv =====
// Self-checking testbench for the bulb exposure sequencer top level.
// Tests directed and random start/tick transactions against an in-bench model of the sequencer.
// Depends on bes_pkg and bulb_exposure_sequencer_top.
module tb_bulb_exposure_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bes_pkg::*;

    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_ITEMS    = 80;
    localparam int NUM_PHASES     = 10;
    localparam int REPORT_LIMIT   = 10;
    localparam int SETTLE_CYCLES  = 4;
    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                item_valid = 1'b0;
    logic                item_ready;
    bes_in_t             item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    bes_out_t            result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;

    // Stimulus and checking bookkeeping
    bes_in_t  queued_items[$];
    bes_out_t due_reports[$];
    int       items_queued = 0;
    int       report_index = 0;
    int       mismatch_count = 0;
    int       sender_idle_pct = 0;
    int       receiver_stall_pct = 0;
    logic     receiver_blocked = 1'b0;
    event     stall_burst;

    // Model copy of the configuration registers
    logic [31:0] bulb_reg, start_lag_reg, end_lag_reg, timeout_reg;
    logic [15:0] pre_focus_reg;
    logic        wait_sync_reg, test_mode_reg;

    // Model copy of the sequencer state
    logic [2:0]           seq_phase;
    logic                 prev_sync;
    logic [FOCUS_W-1:0]   focus_left;
    logic [TIME_BITS-1:0] us_count, fall_stamp, release_stamp, rise_stamp;
    logic [1:0]           err_code;

    bulb_exposure_sequencer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Return the sequencer and its registers to their reset values
    function automatic void reset_sequencer_model();
        bulb_reg      = '0;
        start_lag_reg = '0;
        end_lag_reg   = '0;
        pre_focus_reg = '0;
        wait_sync_reg = 1'b1;
        test_mode_reg = 1'b0;
        timeout_reg   = TIMEOUT_RST;
        seq_phase     = PH_IDLE;
        prev_sync     = 1'b1;
        focus_left    = '0;
        us_count      = '0;
        fall_stamp    = '0;
        release_stamp = '0;
        rise_stamp    = '0;
        err_code      = ERR_NONE;
    endfunction

    // Apply one register write; unknown indexes fall through
    function automatic void record_register(input logic [IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] data);
        case (idx)
            REG_BULB:        bulb_reg = data;
            REG_START_LAG:   start_lag_reg = data;
            REG_END_LAG:     end_lag_reg = data;
            REG_PRE_FOCUS:   pre_focus_reg = data[15:0];
            REG_EXPECT_SYNC: wait_sync_reg = data[0];
            REG_RUN_TEST:    test_mode_reg = data[0];
            REG_TIMEOUT:     timeout_reg = data;
            default:         ;
        endcase
    endfunction

    // Advance the sequencer by one start or tick and build the report it produces
    function automatic bes_out_t sequence_item(input bes_in_t it);
        bes_out_t r;
        longint   bulb_e, slag_e, elag_e, span;
        logic     wait_sync;
        bulb_e    = test_mode_reg ? 64'sd0 : longint'(bulb_reg);
        slag_e    = test_mode_reg ? 64'sd0 : longint'(start_lag_reg);
        elag_e    = test_mode_reg ? 64'sd0 : longint'(end_lag_reg);
        wait_sync = test_mode_reg | wait_sync_reg;
        if (it.func == FUNC_START)
        begin
            // Start is honored only outside a run
            if (seq_phase == PH_IDLE || seq_phase == PH_DONE || seq_phase == PH_ERROR)
            begin
                err_code      = ERR_NONE;
                us_count      = '0;
                fall_stamp    = '0;
                release_stamp = '0;
                rise_stamp    = '0;
                focus_left    = '0;
                prev_sync     = 1'b1;
                if (!it.sync_level)
                begin
                    err_code  = ERR_SYNC;
                    seq_phase = PH_ERROR;
                end
                else if (pre_focus_reg == 16'd0)
                begin
                    us_count  = '0;
                    prev_sync = 1'b1;
                    seq_phase = PH_SYNCIN;
                end
                else
                begin
                    focus_left = FOCUS_W'(pre_focus_reg) * US_PER_MS;
                    seq_phase  = PH_FOCUS;
                end
            end
        end
        else if (seq_phase == PH_FOCUS)
        begin
            // Count down focus time, sync is not watched here
            if (focus_left != '0)
                focus_left = focus_left - 1'b1;
            if (focus_left == '0)
            begin
                us_count  = '0;
                prev_sync = 1'b1;
                seq_phase = PH_SYNCIN;
            end
        end
        else if (seq_phase == PH_SYNCIN || seq_phase == PH_HOLD || seq_phase == PH_SYNCOUT)
        begin
            if (us_count != TIME_MAX)
                us_count = us_count + 1'b1;
            // Sync edge handling
            if (it.sync_level != prev_sync)
            begin
                if (seq_phase == PH_SYNCIN && !it.sync_level)
                begin
                    fall_stamp = us_count;
                    seq_phase  = PH_HOLD;
                end
                else if (seq_phase == PH_SYNCOUT && it.sync_level)
                begin
                    rise_stamp = us_count;
                    seq_phase  = PH_DONE;
                end
                else
                begin
                    err_code  = ERR_SEQ;
                    seq_phase = PH_ERROR;
                end
                prev_sync = it.sync_level;
            end
            // Hold release, or timeout in every other phase
            if (seq_phase == PH_HOLD)
            begin
                if (longint'(us_count - fall_stamp) >= bulb_e - elag_e)
                begin
                    release_stamp = us_count;
                    seq_phase     = PH_SYNCOUT;
                end
            end
            else
            begin
                span = longint'(us_count);
                if ((!wait_sync && seq_phase == PH_SYNCIN && span > bulb_e + slag_e - elag_e)
                    || span > longint'(timeout_reg) + bulb_e)
                begin
                    err_code  = ERR_TIMEOUT;
                    seq_phase = PH_ERROR;
                end
            end
        end

        r            = '0;
        r.shutter    = (seq_phase == PH_SYNCIN || seq_phase == PH_HOLD);
        r.focus      = (seq_phase == PH_FOCUS || seq_phase == PH_SYNCIN || seq_phase == PH_HOLD);
        r.error_code = err_code;
        case (seq_phase)
            PH_IDLE:  r.status = ST_IDLE;
            PH_DONE:  r.status = ST_DONE;
            PH_ERROR: r.status = ST_FAIL;
            default:  r.status = ST_BUSY;
        endcase
        if (seq_phase == PH_DONE)
        begin
            r.start_diff  = OUT_W'(fall_stamp);
            r.stop_diff   = OUT_W'(rise_stamp - release_stamp);
            r.actual_time = OUT_W'(rise_stamp - fall_stamp);
        end
        return r;
    endfunction

    function automatic void queue_item(input logic func, input logic sync_level);
        bes_in_t it;
        it.func       = func;
        it.sync_level = sync_level;
        queued_items.push_back(it);
        items_queued++;
    endfunction

    // Flip a sync sample now and then to provoke sequence errors
    function automatic logic jitter(input logic lvl);
        return lvl ^ ($urandom_range(49) == 0);
    endfunction

    // Queue one exposure with jittered sync samples: start, focus, wait for fall, hold, wait for rise
    task automatic queue_run();
        int     n_wait, n_low, n_high, lag_hint;
        longint bulb_e, slag_e, elag_e, hold_need;
        bulb_e    = test_mode_reg ? 64'sd0 : longint'(bulb_reg);
        slag_e    = test_mode_reg ? 64'sd0 : longint'(start_lag_reg);
        elag_e    = test_mode_reg ? 64'sd0 : longint'(end_lag_reg);
        hold_need = bulb_e - elag_e;
        if (hold_need < 0)
            hold_need = 0;
        if (hold_need > 24)
            hold_need = $urandom_range(24);
        lag_hint = (slag_e > 10) ? 10 : int'(slag_e);
        n_wait   = $urandom_range(lag_hint + 3);
        n_low    = int'(hold_need) + $urandom_range(4);
        if (n_low == 0)
            n_low = 1;
        n_high = $urandom_range(1, 3);
        queue_item(FUNC_START, 1'b1);
        repeat (int'(pre_focus_reg) * 1000)
            queue_item(FUNC_TICK, $urandom_range(1) == 1);
        repeat (n_wait)
            queue_item(FUNC_TICK, jitter(1'b1));
        repeat (n_low)
            queue_item(FUNC_TICK, jitter(1'b0));
        repeat (n_high)
            queue_item(FUNC_TICK, jitter(1'b1));
    endtask

    // Write one configuration register through its handshake
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        record_register(idx, data);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Hold until every queued item is sent and every report has come back
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (queued_items.size() != 0 || item_valid || due_reports.size() != 0);
    endtask

    // Item driver: record each transaction, then offer the next item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
                due_reports.push_back(sequence_item(item));
            if (!item_valid || item_ready)
            begin
                if (queued_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item       <= queued_items.pop_front();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each transaction with the oldest report due
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (due_reports.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("result %0d arrived with no report due", report_index);
                    mismatch_count++;
                end
                else
                begin
                    bes_out_t want;
                    want = due_reports.pop_front();
                    if (result.shutter !== want.shutter || result.focus !== want.focus
                        || result.status !== want.status
                        || result.error_code !== want.error_code
                        || result.start_diff !== want.start_diff
                        || result.stop_diff !== want.stop_diff
                        || result.actual_time !== want.actual_time)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                        begin
                            $display("result %0d expected sh=%0b fo=%0b st=%0d err=%0d %0d %0d %0d",
                                     report_index, want.shutter, want.focus, want.status,
                                     want.error_code, want.start_diff, want.stop_diff,
                                     want.actual_time);
                            $display("result %0d actual   sh=%0b fo=%0b st=%0d err=%0d %0d %0d %0d",
                                     report_index, result.shutter, result.focus, result.status,
                                     result.error_code, result.start_diff, result.stop_diff,
                                     result.actual_time);
                        end
                        mismatch_count++;
                    end
                end
                report_index++;
            end
            result_ready <= !receiver_blocked && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Long receiver hold-off so the result path backs up into the input
    always
    begin
        @(stall_burst);
        @(posedge clk);
        receiver_blocked <= 1'b1;
        repeat (HOLDOFF_CYCLES)
            @(posedge clk);
        receiver_blocked <= 1'b0;
    end

    // Stimulus sequence
    initial
    begin
        logic [31:0] bulb_val, slag_val, elag_val, tmo_val;
        logic [15:0] pre_val;
        logic        wait_bit, test_bit;
        int          mark;
        reset_sequencer_model();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: idle ticks, start with sync low, busy start, zero bulb run
        queue_item(FUNC_TICK, 1'b0);
        queue_item(FUNC_TICK, 1'b1);
        queue_item(FUNC_START, 1'b0);
        queue_item(FUNC_START, 1'b1);
        queue_item(FUNC_START, 1'b1);
        queue_item(FUNC_TICK, 1'b0);
        queue_item(FUNC_TICK, 1'b1);
        queue_item(FUNC_TICK, 1'b1);
        wait_quiet();

        // Directed: short bulb run, sequence error, timeout
        write_register(REG_BULB, 32'd3);
        write_register(REG_TIMEOUT, 32'd4);
        queue_item(FUNC_START, 1'b1);
        repeat (4)
            queue_item(FUNC_TICK, 1'b0);
        queue_item(FUNC_TICK, 1'b1);
        queue_item(FUNC_START, 1'b1);
        queue_item(FUNC_TICK, 1'b0);
        queue_item(FUNC_TICK, 1'b1);
        queue_item(FUNC_START, 1'b1);
        repeat (8)
            queue_item(FUNC_TICK, 1'b1);

        // Random phases, each with its own register setting and idling mode
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_quiet();
            case (p % 4)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
                default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
            endcase
            bulb_val = $urandom_range(12);
            slag_val = $urandom_range(8);
            elag_val = $urandom_range(6);
            tmo_val  = $urandom_range(2, 40);
            pre_val  = 16'd0;
            wait_bit = $urandom_range(1);
            test_bit = 1'b0;
            case (p)
                1:
                begin
                    // negative lag sum with lag-based timeout
                    elag_val = bulb_val + slag_val + $urandom_range(1, 5);
                    wait_bit = 1'b0;
                end
                3:
                begin
                    test_bit = 1'b1;
                    bulb_val = $urandom;
                    slag_val = $urandom;
                    elag_val = $urandom;
                end
                4:
                begin
                    bulb_val = 32'hFFFF_FFFF;
                    slag_val = 32'hFFFF_FFFF;
                    elag_val = 32'hFFFF_FFFF;
                    tmo_val  = 32'hFFFF_FFFF;
                end
                5:
                begin
                    bulb_val = 32'd0;
                    tmo_val  = 32'd0;
                end
                6:       pre_val = 16'd1;
                7:
                begin
                    bulb_val = 32'hFFFF_FFFF;
                    elag_val = 32'd0;
                    tmo_val  = 32'd0;
                end
                8:
                begin
                    slag_val = 32'hFFFF_FFFF;
                    wait_bit = 1'b0;
                end
                default: ;
            endcase
            write_register(REG_BULB, bulb_val);
            write_register(REG_START_LAG, slag_val);
            write_register(REG_END_LAG, elag_val);
            write_register(REG_PRE_FOCUS, {16'($urandom), pre_val});
            write_register(REG_EXPECT_SYNC, {31'($urandom), wait_bit});
            write_register(REG_RUN_TEST, {31'($urandom), test_bit});
            write_register(REG_TIMEOUT, tmo_val);
            write_register(REG_NONE, $urandom);
            if (p == 4)
                -> stall_burst;

            // Mostly well-formed exposures, some random noise between them
            mark = items_queued;
            while (items_queued - mark < PHASE_ITEMS)
            begin
                if ($urandom_range(9) == 0)
                begin
                    repeat ($urandom_range(1, 5))
                        queue_item($urandom_range(1) == 1, $urandom_range(1) == 1);
                end
                else
                    queue_run();
            end
        end

        // Longest pre-focus: start it and watch the focus phase only
        wait_quiet();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        write_register(REG_PRE_FOCUS, {16'($urandom), 16'hFFFF});
        queue_item(FUNC_START, 1'b1);
        repeat (6)
            queue_item(FUNC_TICK, $urandom_range(1) == 1);
        wait_quiet();

        repeat (SETTLE_CYCLES)
            @(posedge clk);
        mismatch_count += due_reports.size();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
